// ----- rtl/interrupt_class_router_unit_assert.svh -----
// assertion macros shared by the interrupt class router checker
`ifndef INTERRUPT_CLASS_ROUTER_UNIT_ASSERT_SVH
`define INTERRUPT_CLASS_ROUTER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define ICR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("icr check failed");

// next-cycle implication, disabled while reset is asserted
`define ICR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("icr check failed");

`endif

// ----- rtl/icr_pkg.sv -----
// types, constants and codes of the interrupt class router
package icr_pkg;

  localparam int unsigned NUM_IRQS_DEF = 1020;
  localparam int unsigned NUM_CPUS     = 8;

  localparam int unsigned IRQ_W  = 10;
  localparam int unsigned MASK_W = 8;
  localparam int unsigned CPU_W  = 3;
  localparam int unsigned OFF_W  = 16;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned IN_W   = 40;
  localparam int unsigned OUT_W  = 88;

  localparam logic [MASK_W-1:0] CPU_MASK =
    (NUM_CPUS >= MASK_W) ? '1 : MASK_W'((1 << NUM_CPUS) - 1);

  localparam logic [OFF_W-1:0]  REG_CLASS_PHYS = 16'hE008;
  localparam logic [OFF_W-1:0]  REG_CLASS_VIRT = 16'h0028;
  localparam logic [WORD_W-1:0] VIRT_ID_MASK   = 32'h0000_1FFF;
  localparam logic [WORD_W-1:0] VIRT_CLASS0    = 32'h4000_0000;
  localparam logic [WORD_W-1:0] VIRT_CLASS1    = 32'h8000_0000;
  localparam logic [WORD_W-1:0] SPI_BASE       = 32'd32;
  localparam logic [1:0]        FIELD_CLASS0   = 2'h2;
  localparam logic [1:0]        FIELD_CLASS1   = 2'h1;
  localparam logic [WORD_W-1:0] FIELD_MASK     = 32'h3;

  typedef enum logic [2:0] {
    OUTC_UNSUPPORTED = 3'd0,
    OUTC_BROKEN      = 3'd1,
    OUTC_SINGLE      = 3'd2,
    OUTC_UNCHANGED   = 3'd3,
    OUTC_WRITTEN     = 3'd4
  } outcome_e;

  typedef enum logic [1:0] {
    REG_CLASS0_SET = 2'd0,
    REG_CLASS1_SET = 2'd1,
    REG_VIRTUAL    = 2'd2,
    REG_ROUTING    = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC
  } state_e;

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic finish;
  } icr_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } icr_status_t;

  typedef struct packed {
    logic init;
    logic class1;
    logic class0;
  } icr_entry_t;

  typedef struct packed {
    logic [2:0]        pad;
    logic [CPU_W-1:0]  calling_cpu;
    logic [MASK_W-1:0] online_mask;
    logic [MASK_W-1:0] current_mask;
    logic [MASK_W-1:0] requested_mask;
    logic [IRQ_W-1:0]  irq_index;
  } icr_in_t;

  typedef struct packed {
    logic              pad;
    logic [WORD_W-1:0] write_mask;
    logic [WORD_W-1:0] write_value;
    logic [OFF_W-1:0]  write_offset;
    logic              write_valid;
    logic              in_class1;
    logic              in_class0;
    logic              routing_mode;
    outcome_e          outcome;
  } icr_out_t;

endpackage

// ----- rtl/icr_ram.sv -----
// generic single-write, single-read ram with registered read data
module icr_ram #(
  parameter int unsigned Width = 3,
  parameter int unsigned Depth = 1020
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/icr_ctrl.sv -----
// sequencer: reset clearing pass, item capture and result hand-off
module icr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  icr_pkg::icr_status_t status_i,
  output icr_pkg::icr_cmd_t    cmd_o
);
  import icr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        // hold the item until the output register can take the result
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- rtl/icr_dpath.sv -----
// config registers, class store, classification logic and result register
module icr_dpath #(
  parameter int unsigned NumIrqs = icr_pkg::NUM_IRQS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  icr_pkg::icr_cmd_t           cmd_i,
  output icr_pkg::icr_status_t        status_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [icr_pkg::MASK_W-1:0]  cfg_data_i,
  input  logic [icr_pkg::IN_W-1:0]    in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [icr_pkg::OUT_W-1:0]   out_data_o
);
  import icr_pkg::*;

  localparam int unsigned AddrW = $clog2(NumIrqs);
  localparam logic [IRQ_W-1:0] IrqLimit = IRQ_W'(NumIrqs);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(NumIrqs - 1);

  logic [MASK_W-1:0] class0_set_q, class1_set_q;
  logic              virtual_q, routing_q;
  icr_in_t           item_q;
  icr_in_t           in_item;
  icr_out_t          out_q, res;
  logic              out_valid_q;
  logic [AddrW-1:0]  clr_cnt_q;

  icr_entry_t        rd_entry, new_entry, wr_entry;
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;

  logic [MASK_W-1:0] req, cur, onl, cpu_bit, c0, c1, aff;
  logic              irq_ok, broken0, broken1, single, k0, k1, need;
  logic [4:0]        shamt;
  logic [1:0]        field;

  assign in_item = icr_in_t'(in_data_i);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class0_set_q <= '0;
      class1_set_q <= '0;
      virtual_q    <= 1'b0;
      routing_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CLASS0_SET: class0_set_q <= cfg_data_i;
        REG_CLASS1_SET: class1_set_q <= cfg_data_i;
        REG_VIRTUAL:    virtual_q    <= cfg_data_i[0];
        REG_ROUTING:    routing_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clearing pass address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_step && !status_o.clear_last) begin
      clr_cnt_q <= clr_cnt_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item;
    end
  end

  icr_ram #(
    .Width ($bits(icr_entry_t)),
    .Depth (NumIrqs)
  ) u_class_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.capture),
    .raddr_i (in_item.irq_index[AddrW-1:0]),
    .rdata_o (rd_entry)
  );

  assign ram_we    = cmd_i.clear_step || (cmd_i.finish && irq_ok);
  assign ram_waddr = cmd_i.clear_step ? clr_cnt_q : item_q.irq_index[AddrW-1:0];
  assign wr_entry  = cmd_i.clear_step ? icr_entry_t'('0) : new_entry;

  // classification
  assign req     = item_q.requested_mask & CPU_MASK;
  assign cur     = item_q.current_mask & CPU_MASK;
  assign onl     = item_q.online_mask & CPU_MASK;
  assign cpu_bit = (MASK_W'(1) << item_q.calling_cpu) & CPU_MASK;
  assign c0      = class0_set_q & CPU_MASK;
  assign c1      = class1_set_q & CPU_MASK;
  assign irq_ok  = routing_q && (item_q.irq_index < IrqLimit);

  // current affinity inside a class with every cpu of it offline, caller included
  assign broken0 = ((cur & ~c0) == '0) && ((onl & c0) == '0) &&
                   ((onl & cpu_bit) == '0) && ((c0 & cpu_bit) != '0);
  assign broken1 = ((cur & ~c1) == '0) && ((onl & c1) == '0) &&
                   ((onl & cpu_bit) == '0) && ((c1 & cpu_bit) != '0);
  assign single  = (req & (req - MASK_W'(1))) == '0;
  assign aff     = ((req & onl) == '0) ? onl : req;
  assign k0      = ((aff & ~c0) == '0) || ((aff & ~c1) != '0);
  assign k1      = ((aff & ~c0) != '0);
  assign shamt   = {item_q.irq_index[3:0], 1'b0};
  assign field   = (k0 ? FIELD_CLASS0 : 2'b00) | (k1 ? FIELD_CLASS1 : 2'b00);

  always_comb begin
    if (virtual_q && !rd_entry.init && k0 && !k1) begin
      need = 1'b0;
    end else if (rd_entry.init && (k0 == rd_entry.class0) && (k1 == rd_entry.class1)) begin
      need = 1'b0;
    end else begin
      need = 1'b1;
    end
  end

  always_comb begin
    res         = '0;
    res.outcome = OUTC_UNSUPPORTED;
    new_entry   = rd_entry;
    if (irq_ok) begin
      if (broken0 || broken1) begin
        res.outcome   = OUTC_BROKEN;
        res.in_class0 = rd_entry.class0;
        res.in_class1 = rd_entry.class1;
      end else if (single) begin
        res.outcome      = OUTC_SINGLE;
        new_entry.class0 = 1'b0;
        new_entry.class1 = 1'b0;
      end else begin
        new_entry.init   = 1'b1;
        new_entry.class0 = k0;
        new_entry.class1 = k1;
        res.outcome      = need ? OUTC_WRITTEN : OUTC_UNCHANGED;
        res.routing_mode = 1'b1;
        res.in_class0    = k0;
        res.in_class1    = k1;
        if (need) begin
          res.write_valid = 1'b1;
          if (virtual_q) begin
            res.write_offset = REG_CLASS_VIRT;
            res.write_value  = ((WORD_W'(item_q.irq_index) + SPI_BASE) & VIRT_ID_MASK) |
                               (k0 ? VIRT_CLASS0 : '0) | (k1 ? VIRT_CLASS1 : '0);
            res.write_mask   = '1;
          end else begin
            res.write_offset = REG_CLASS_PHYS + {8'b0, item_q.irq_index[9:4], 2'b00};
            res.write_value  = WORD_W'(field) << shamt;
            res.write_mask   = FIELD_MASK << shamt;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q <= res;
    end
  end

  assign status_o.clear_last = (clr_cnt_q == LastAddr);
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o         = out_valid_q;
  assign out_data_o          = OUT_W'(out_q);

endmodule

// ----- rtl/interrupt_class_router_unit.sv -----
// top level of the interrupt class router
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+-------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | affinity request item
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | routing result item
//  cfg       | in        | cfg_valid_i/cfg_ready_o      | register index and data
//
//  the accept cycle reads the class store; in the compute state the block then
//  classifies the item, updates the store and loads the result register
//  a new item is taken once the previous one has moved to the result register
//  after reset the class store is cleared one entry a cycle, every entry in turn,
//  with s_axis_tready low; config writes are taken in every cycle
//  a stalled m_axis holds the block in its compute cycle
module interrupt_class_router_unit #(
  parameter int unsigned NumIrqs = icr_pkg::NUM_IRQS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // irq_index[9:0], requested_mask[17:10], current_mask[25:18],
  // online_mask[33:26], calling_cpu[36:34], zero pad[39:37]
  input  logic [icr_pkg::IN_W-1:0]   s_axis_tdata,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // outcome[2:0], routing_mode[3], in_class0[4], in_class1[5], write_valid[6],
  // write_offset[22:7], write_value[54:23], write_mask[86:55], zero pad[87]
  output logic [icr_pkg::OUT_W-1:0]  m_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [icr_pkg::MASK_W-1:0] cfg_data_i
);
  import icr_pkg::*;

  icr_cmd_t    cmd;
  icr_status_t status;

  assign cfg_ready_o = 1'b1;

  icr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  icr_dpath #(
    .NumIrqs (NumIrqs)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ----- rtl/icr_checker.sv -----
// port-level checker for the interrupt class router and its bind
`include "interrupt_class_router_unit_assert.svh"

module icr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic [icr_pkg::IN_W-1:0]   s_axis_tdata,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic [icr_pkg::OUT_W-1:0]  m_axis_tdata,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_o,
  input logic [1:0]                 cfg_index_i,
  input logic [icr_pkg::MASK_W-1:0] cfg_data_i
);
  import icr_pkg::*;

  // a stalled result stays put
  `ICR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // one item at a time: no accept right after an accept
  `ICR_ASSERT_NEXT(a_no_back_to_back, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // write flag and routing mode follow the outcome code
  `ICR_ASSERT_NOW(a_outcome_flags, clk_i, rst_ni, m_axis_tvalid, (m_axis_tdata[6] == (m_axis_tdata[2:0] == OUTC_WRITTEN)) && (m_axis_tdata[3] == ((m_axis_tdata[2:0] == OUTC_WRITTEN) || (m_axis_tdata[2:0] == OUTC_UNCHANGED))))

  // no write issued: offset, value and mask are zero
  `ICR_ASSERT_NOW(a_no_write_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[6], m_axis_tdata[87:7] == '0)

endmodule

bind interrupt_class_router_unit icr_checker u_icr_checker (.*);
